>>> src/lksa_pkg.sv
package lksa_pkg;

  localparam int POLY_DEGREE = 1024;
  localparam int POLY_COUNT  = 2;
  localparam int KEY_LENGTH  = 1024;
  localparam int ACC_SIZE    = POLY_COUNT * POLY_DEGREE;
  localparam int ACC_AW      = $clog2(ACC_SIZE);

  localparam int WORD_W      = 32;
  localparam int OP_W        = 2;
  localparam int COEFF_W     = 11;
  localparam int DIGIT_IDX_W = 5;
  localparam int MASK_IDX_W  = 10;
  localparam int CFG_W       = 5;
  localparam int CFG_IDX_W   = 1;
  localparam int DIGIT_W     = 31;
  localparam int RMASK_W     = WORD_W + 1;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE = 2'd0,
    OP_LOAD  = 2'd1,
    OP_APPLY = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASE_BITS = 1'b0,
    REG_DIGITS    = 1'b1
  } cfg_reg_t;

  // Result of the key-word decomposition, handed to the pipeline.
  typedef struct packed {
    logic               key_hit;
    logic [DIGIT_W-1:0] digit;
  } decomp_t;

endpackage

>>> src/lksa_acc_ram.sv
module lksa_acc_ram (
  input  logic                              clk,
  input  logic                              we,
  input  logic [lksa_pkg::ACC_AW-1:0]       waddr,
  input  logic [lksa_pkg::WORD_W-1:0]       wdata,
  input  logic                              re,
  input  logic [lksa_pkg::ACC_AW-1:0]       raddr,
  output logic [lksa_pkg::WORD_W-1:0]       rdata
);
  import lksa_pkg::*;

  logic [WORD_W-1:0] mem [ACC_SIZE];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read-before-write; the pipeline forwards around same-address writes.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> src/lksa_decomp.sv
module lksa_decomp (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [lksa_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [lksa_pkg::CFG_W-1:0]           cfg_data,
  input  logic                                 load,
  input  logic [lksa_pkg::DIGIT_IDX_W-1:0]     digit_index,
  input  logic [lksa_pkg::MASK_IDX_W-1:0]      mask_index,
  input  logic [lksa_pkg::WORD_W-1:0]          data_value,
  output lksa_pkg::decomp_t                    decomp
);
  import lksa_pkg::*;

  logic [CFG_W-1:0]      base_bits;
  logic [CFG_W-1:0]      digits;
  logic [RMASK_W-1:0]    rounded_mask;
  logic [MASK_IDX_W-1:0] loaded_mask_index;

  logic [2*CFG_W-1:0]    width_prod;
  logic [RMASK_W-1:0]    offset;
  logic [10:0]           top_bit;
  logic [6:0]            shamt;
  logic [95:0]           window;
  logic [95:0]           shifted;
  logic [DIGIT_W-1:0]    field_mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_bits <= CFG_W'(2);
      digits    <= CFG_W'(8);
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_BASE_BITS: base_bits <= cfg_data;
        REG_DIGITS:    digits    <= cfg_data;
      endcase
    end
  end

  // Rounding offset 2^(31 - base_bits*digits), zero when the product is too wide.
  always_comb begin
    width_prod = (2*CFG_W)'(base_bits) * (2*CFG_W)'(digits);
    if (width_prod > (2*CFG_W)'(31)) begin
      offset = '0;
    end else begin
      offset = RMASK_W'(1) << (5'd31 - width_prod[4:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rounded_mask      <= '0;
      loaded_mask_index <= '0;
    end else if (load && (32'(mask_index) < KEY_LENGTH)) begin
      rounded_mask      <= {data_value[WORD_W-1], data_value} + offset;
      loaded_mask_index <= mask_index;
    end
  end

  // Digit field sits at bits [32-top +: base_bits] of the sign-extended mask;
  // positions below bit 0 read as zero.
  always_comb begin
    top_bit    = 11'({1'b0, digit_index} + 6'd1) * 11'(base_bits);
    shamt      = 7'(11'd64 - top_bit);
    window     = {{31{rounded_mask[RMASK_W-1]}}, rounded_mask, 32'b0};
    shifted    = window >> shamt;
    field_mask = DIGIT_W'((32'd1 << base_bits) - 32'd1);
    if ((top_bit == 11'd0) || (top_bit >= 11'd64)) begin
      decomp.digit = '0;
    end else begin
      decomp.digit = shifted[DIGIT_W-1:0] & field_mask;
    end
    decomp.key_hit = (mask_index == loaded_mask_index) && (digit_index < digits);
  end

endmodule

>>> src/lwe_key_switch_accumulate_unit.sv
// Read path: a read request's result passes the s1 and s2 registers, then the
// registered response. Throughput: one request per cycle while req_stall is low;
// the accumulator RAM does one read and one write per cycle, with the
// read-modify-write hazards covered by forwarding. A stalled read result holds
// the pipeline only while a read waits behind it. Reset: synchronous; afterwards a
// clearing pass zeroes all ACC_SIZE = 2048 entries, one per cycle, with req_stall high.
module lwe_key_switch_accumulate_unit (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   req_valid,
  output logic                                   req_stall,
  input  logic [lksa_pkg::OP_W-1:0]              opcode,
  input  logic [lksa_pkg::COEFF_W-1:0]           coeff_index,
  input  logic [lksa_pkg::DIGIT_IDX_W-1:0]       digit_index,
  input  logic [lksa_pkg::MASK_IDX_W-1:0]        mask_index,
  input  logic signed [lksa_pkg::WORD_W-1:0]     data_value,
  output logic                                   rsp_valid,
  input  logic                                   rsp_stall,
  output logic [lksa_pkg::COEFF_W-1:0]           read_index,
  output logic signed [lksa_pkg::WORD_W-1:0]     read_value,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [lksa_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [lksa_pkg::CFG_W-1:0]             cfg_data
);
  import lksa_pkg::*;

  op_t                req_op;
  logic               accept;
  logic               adv;
  logic               in_acc;
  logic               s1_we_next;
  decomp_t            decomp;

  logic               clearing;
  logic [ACC_AW-1:0]  clear_addr;

  logic               mem_we;
  logic [ACC_AW-1:0]  mem_waddr;
  logic [WORD_W-1:0]  mem_wdata;
  logic [WORD_W-1:0]  mem_rdata;

  logic               lw_valid;
  logic [ACC_AW-1:0]  lw_addr;
  logic [WORD_W-1:0]  lw_data;

  logic               s1_valid;
  op_t                s1_op;
  logic               s1_we;
  logic               s1_in_acc;
  logic [ACC_AW-1:0]  s1_addr;
  logic [COEFF_W-1:0] s1_index;
  logic [DIGIT_W-1:0] s1_digit;
  logic [WORD_W-1:0]  s1_data;
  logic [WORD_W-1:0]  s1_full_prod;
  logic [WORD_W-1:0]  s1_acc;

  logic               s2_valid;
  op_t                s2_op;
  logic               s2_we;
  logic               s2_in_acc;
  logic [ACC_AW-1:0]  s2_addr;
  logic [COEFF_W-1:0] s2_index;
  logic [WORD_W-1:0]  s2_data;
  logic [WORD_W-1:0]  s2_prod;
  logic [WORD_W-1:0]  s2_acc;
  logic [WORD_W-1:0]  s2_new;
  logic               s2_is_read;

  assign req_op     = op_t'(opcode);
  assign cfg_ready  = 1'b1;
  assign s2_is_read = s2_valid && (s2_op == OP_READ);
  assign adv        = !(rsp_valid && rsp_stall && s2_is_read);
  assign req_stall  = clearing || !adv;
  assign accept     = req_valid && !req_stall;
  assign in_acc     = 32'(coeff_index) < ACC_SIZE;

  lksa_decomp u_decomp (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .load        (accept && (req_op == OP_LOAD)),
    .digit_index (digit_index),
    .mask_index  (mask_index),
    .data_value  (data_value),
    .decomp      (decomp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing   <= 1'b1;
      clear_addr <= '0;
    end else if (clearing) begin
      clear_addr <= clear_addr + ACC_AW'(1);
      if (clear_addr == ACC_AW'(ACC_SIZE - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  assign mem_we    = clearing || (adv && s2_valid && s2_we);
  assign mem_waddr = clearing ? clear_addr : s2_addr;
  assign mem_wdata = clearing ? '0 : s2_new;

  lksa_acc_ram u_acc_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (accept),
    .raddr (ACC_AW'(coeff_index)),
    .rdata (mem_rdata)
  );

  // Most recent RAM write, covers a write landing on the edge of the read.
  always_ff @(posedge clk) begin
    if (rst) begin
      lw_valid <= 1'b0;
    end else if (mem_we) begin
      lw_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      lw_addr <= mem_waddr;
      lw_data <= mem_wdata;
    end
  end

  always_comb begin
    unique case (req_op)
      OP_WRITE: s1_we_next = in_acc;
      OP_APPLY: s1_we_next = in_acc && decomp.key_hit;
      OP_LOAD:  s1_we_next = 1'b0;
      OP_READ:  s1_we_next = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_op     <= req_op;
      s1_we     <= s1_we_next;
      s1_in_acc <= in_acc;
      s1_addr   <= ACC_AW'(coeff_index);
      s1_index  <= coeff_index;
      s1_digit  <= decomp.digit;
      s1_data   <= data_value;
    end
  end

  // Only the low word of the product matters modulo 2^32.
  assign s1_full_prod = WORD_W'(s1_digit) * s1_data;

  always_comb begin
    priority if (s2_valid && s2_we && (s2_addr == s1_addr)) begin
      s1_acc = s2_new;
    end else if (lw_valid && (lw_addr == s1_addr)) begin
      s1_acc = lw_data;
    end else begin
      s1_acc = mem_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_op     <= s1_op;
      s2_we     <= s1_we;
      s2_in_acc <= s1_in_acc;
      s2_addr   <= s1_addr;
      s2_index  <= s1_index;
      s2_data   <= s1_data;
      s2_prod   <= s1_full_prod;
      s2_acc    <= s1_acc;
    end
  end

  assign s2_new = (s2_op == OP_WRITE) ? s2_data : (s2_acc - s2_prod);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (adv && s2_is_read) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s2_is_read) begin
      read_index <= s2_index;
      read_value <= s2_in_acc ? s2_acc : '0;
    end
  end

endmodule
